// ----- rtl/appsp_pkg.sv -----
// ----------------------------------------------------------------------------
// appsp_pkg
// Shared types and constants of the palette path stream parser: parse
// phases, record kinds, queue entry layout and the fixed path prefix.
// ----------------------------------------------------------------------------
package appsp_pkg;

	// default limits handed to the top level
	localparam int MAX_PATH_LEN_DEF = 256;
	localparam int MAX_ENTRIES_DEF  = 256;
	localparam int MIN_FILE_LEN_DEF = 64;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_FILE_LENGTH = '0;

	// fixed field widths
	localparam int IDX_W  = 9;
	localparam int WORD_W = 32;

	// search and metadata constants
	localparam logic [31:0] PREFIX_WORD    = 32'h6172_745C;
	localparam logic [31:0] COUNT_LO       = 32'd1;
	localparam logic [31:0] COUNT_HI       = 32'd200;
	localparam logic [31:0] SEARCH_MIN_POS = 32'd7;
	localparam logic [31:0] PREFIX_BACK    = 32'd3;
	localparam logic [3:0]  META_FIRST     = 4'd1;
	localparam logic [3:0]  META_WORD_END  = 4'd8;
	localparam logic [3:0]  META_LAST      = 4'd12;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_DIFF,
		PH_NPRE,
		PH_NORM,
		PH_META,
		PH_NEXT,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PATH    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_ABANDON = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	// one queue entry: an optional path/done/abandon record and an
	// optional end summary that follows it
	typedef struct packed {
		logic              has_rec;
		kind_t             kind;
		logic              which;
		logic [7:0]        pbyte;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] tile;
		logic [WORD_W-1:0] inten;
		logic              has_sum;
		logic [WORD_W-1:0] pal;
		logic [IDX_W-1:0]  cnt;
		logic              ok;
	} entry_t;

	// prefix character at a position of "art\"
	function automatic logic [7:0] prefix_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0: ch = 8'h61;
			2'd1: ch = 8'h72;
			2'd2: ch = 8'h74;
			default: ch = 8'h5C;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/appsp_queue.sv -----
// ----------------------------------------------------------------------------
// appsp_queue
// Short register queue that decouples the byte parser from the record
// output stage.
// ----------------------------------------------------------------------------
module appsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  appsp_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output appsp_pkg::entry_t head,
	output logic            empty
);
	import appsp_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/appsp_front.sv -----
// ----------------------------------------------------------------------------
// appsp_front
// Byte parser: holds the file length register and the parse state, and
// classifies each accepted byte into at most one record plus a summary.
// ----------------------------------------------------------------------------
module appsp_front #(
	parameter int MAX_PATH_LEN = appsp_pkg::MAX_PATH_LEN_DEF,
	parameter int MAX_ENTRIES  = appsp_pkg::MAX_ENTRIES_DEF,
	parameter int MIN_FILE_LEN = appsp_pkg::MIN_FILE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic [31:0]       cfg_value,
	output logic [31:0]       file_length,
	input  logic              byte_valid,
	input  logic [7:0]        data_byte,
	input  logic              queue_full,
	output logic              push,
	output appsp_pkg::entry_t push_entry
);
	import appsp_pkg::*;

	localparam int FLEN_W = $clog2(MAX_PATH_LEN + 1);
	localparam int ENT_W  = $clog2(MAX_ENTRIES + 2);

	logic [31:0]       file_len_q, file_len_d;
	logic [31:0]       pos_q, pos_d;
	logic [63:0]       recent_q, recent_d;
	phase_t            phase_q, phase_d;
	logic [FLEN_W-1:0] flen_q, flen_d;
	logic [ENT_W-1:0]  entries_q, entries_d;
	logic [31:0]       pal_q, pal_d;
	logic [3:0]        meta_cnt_q, meta_cnt_d;
	logic [63:0]       meta_q, meta_d;

	logic   accept;
	logic   last;
	logic   abandon;
	entry_t ent;

	assign file_length = file_len_q;
	assign accept      = byte_valid && !queue_full;
	assign last        = (pos_q == file_len_q - 32'd1);
	assign push_entry  = ent;
	assign push        = ent.has_rec || ent.has_sum;

	// parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len_q <= '0;
			pos_q      <= '0;
			recent_q   <= '0;
			phase_q    <= PH_SEARCH;
			flen_q     <= '0;
			entries_q  <= '0;
			pal_q      <= '0;
			meta_cnt_q <= '0;
			meta_q     <= '0;
		end else begin
			file_len_q <= file_len_d;
			pos_q      <= pos_d;
			recent_q   <= recent_d;
			phase_q    <= phase_d;
			flen_q     <= flen_d;
			entries_q  <= entries_d;
			pal_q      <= pal_d;
			meta_cnt_q <= meta_cnt_d;
			meta_q     <= meta_d;
		end
	end

	// next state and records for the current byte
	always_comb begin
		file_len_d = file_len_q;
		pos_d      = pos_q;
		recent_d   = recent_q;
		phase_d    = phase_q;
		flen_d     = flen_q;
		entries_d  = entries_q;
		pal_d      = pal_q;
		meta_cnt_d = meta_cnt_q;
		meta_d     = meta_q;
		abandon    = 1'b0;
		ent        = '0;

		if (cfg_wr) begin
			// new file length restarts the parser
			file_len_d = cfg_value;
			pos_d      = '0;
			recent_d   = '0;
			phase_d    = PH_SEARCH;
			flen_d     = '0;
			entries_d  = '0;
			pal_d      = '0;
			meta_cnt_d = '0;
			meta_d     = '0;
		end else if (accept && (pos_q < file_len_q)) begin
			pos_d    = pos_q + 32'd1;
			recent_d = {recent_q[55:0], data_byte};

			if (file_len_q < 32'(MIN_FILE_LEN)) begin
				// short file: only an empty summary on the last byte
				ent.has_sum = last;
			end else begin
				case (phase_q)
					PH_SEARCH: begin
						if ((pos_q >= SEARCH_MIN_POS) && !last &&
							(recent_d[31:0] == PREFIX_WORD) &&
							(recent_d[63:32] > COUNT_LO) &&
							(recent_d[63:32] < COUNT_HI)) begin
							pal_d   = pos_q - PREFIX_BACK;
							phase_d = PH_DIFF;
							flen_d  = FLEN_W'(4);
						end
					end
					PH_DIFF, PH_NORM: begin
						if (last) begin
							abandon = 1'b1;
						end else if (data_byte == 8'd0) begin
							flen_d = '0;
							if (phase_q == PH_DIFF) begin
								phase_d = PH_NPRE;
							end else begin
								phase_d    = PH_META;
								meta_cnt_d = '0;
								meta_d     = '0;
							end
						end else if (flen_q >= FLEN_W'(MAX_PATH_LEN)) begin
							abandon = 1'b1;
						end else begin
							ent.has_rec = 1'b1;
							ent.kind    = KIND_PATH;
							ent.which   = (phase_q == PH_NORM);
							ent.pbyte   = data_byte;
							ent.idx     = IDX_W'(entries_q);
							flen_d      = flen_q + FLEN_W'(1);
						end
					end
					PH_NPRE: begin
						if (last || (flen_q > FLEN_W'(3)) ||
							(data_byte != prefix_char(flen_q[1:0]))) begin
							abandon = 1'b1;
						end else begin
							flen_d = flen_q + FLEN_W'(1);
							if (flen_q == FLEN_W'(3)) begin
								phase_d = PH_NORM;
							end
						end
					end
					PH_META: begin
						if ((meta_cnt_q >= META_FIRST) && (meta_cnt_q <= META_WORD_END)) begin
							meta_d = {meta_q[55:0], data_byte};
						end
						if (meta_cnt_q >= META_LAST) begin
							ent.has_rec = 1'b1;
							ent.kind    = KIND_DONE;
							ent.idx     = IDX_W'(entries_q);
							ent.tile    = meta_d[63:32];
							ent.inten   = meta_d[31:0];
							entries_d   = entries_q + ENT_W'(1);
							flen_d      = '0;
							phase_d     = (entries_d > ENT_W'(MAX_ENTRIES)) ? PH_HALT : PH_NEXT;
						end else if (last) begin
							abandon = 1'b1;
						end else begin
							meta_cnt_d = meta_cnt_q + 4'd1;
						end
					end
					PH_NEXT: begin
						if ((flen_q > FLEN_W'(3)) ||
							(data_byte != prefix_char(flen_q[1:0]))) begin
							phase_d = PH_HALT;
						end else begin
							flen_d = flen_q + FLEN_W'(1);
							if (flen_q == FLEN_W'(3)) begin
								phase_d = last ? PH_HALT : PH_DIFF;
							end
						end
					end
					default: begin
					end
				endcase

				// broken entry
				if (abandon) begin
					ent.has_rec = 1'b1;
					ent.kind    = KIND_ABANDON;
					ent.idx     = IDX_W'(entries_q);
					phase_d     = PH_HALT;
				end

				// end summary on the last byte
				if (last) begin
					ent.has_sum = 1'b1;
					ent.pal     = pal_d;
					ent.cnt     = IDX_W'(entries_d);
					ent.ok      = (entries_d != '0);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALT && !cfg_wr) |=> (phase_q == PH_HALT))
		else $error("parser left halt without restart");
	a_pair_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ent.has_rec && ent.has_sum) |-> last)
		else $error("two records from a byte that is not the last");
`endif

endmodule

// ----- rtl/appsp_back.sv -----
// ----------------------------------------------------------------------------
// appsp_back
// Record output stage: drains queue entries into the output register one
// record per cycle unless rec_stall holds it; record first, summary after.
// ----------------------------------------------------------------------------
module appsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  appsp_pkg::entry_t head,
	input  logic              empty,
	output logic              pop,
	input  logic              rec_stall,
	output logic              rec_valid,
	output logic [1:0]        record_kind,
	output logic              which_path,
	output logic [7:0]        path_byte,
	output logic [8:0]        entry_index,
	output logic [31:0]       tile_scale_bits,
	output logic [31:0]       intensity_bits,
	output logic [31:0]       table_offset,
	output logic [8:0]        entry_count,
	output logic              parse_ok,
	output logic              last_of_run
);
	import appsp_pkg::*;

	logic sel_q;
	logic valid_q;
	logic load;
	logic take;
	logic use_rec;
	logic last_in_entry;

	logic [1:0]        kind_q;
	logic              which_q;
	logic [7:0]        pbyte_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] tile_q;
	logic [WORD_W-1:0] inten_q;
	logic [WORD_W-1:0] pal_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              ok_q;
	logic              last_q;

	assign load          = !valid_q || !rec_stall;
	assign take          = load && !empty;
	assign use_rec       = head.has_rec && !sel_q;
	assign last_in_entry = !use_rec || !head.has_sum;
	assign pop           = take && last_in_entry;

	// output handshake and entry half select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (take) begin
				sel_q <= !last_in_entry;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (use_rec) begin
				kind_q  <= head.kind;
				which_q <= head.which;
				pbyte_q <= head.pbyte;
				idx_q   <= head.idx;
				tile_q  <= head.tile;
				inten_q <= head.inten;
				pal_q   <= '0;
				cnt_q   <= '0;
				ok_q    <= 1'b0;
			end else begin
				kind_q  <= KIND_SUMMARY;
				which_q <= 1'b0;
				pbyte_q <= '0;
				idx_q   <= '0;
				tile_q  <= '0;
				inten_q <= '0;
				pal_q   <= head.pal;
				cnt_q   <= head.cnt;
				ok_q    <= head.ok;
			end
			last_q <= last_in_entry;
		end
	end

	assign rec_valid       = valid_q;
	assign record_kind     = kind_q;
	assign which_path      = which_q;
	assign path_byte       = pbyte_q;
	assign entry_index     = idx_q;
	assign tile_scale_bits = tile_q;
	assign intensity_bits  = inten_q;
	assign table_offset    = pal_q;
	assign entry_count     = cnt_q;
	assign parse_ok        = ok_q;
	assign last_of_run     = last_q;

`ifndef NO_ASSERTIONS
	a_sel_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (!empty && head.has_rec && head.has_sum))
		else $error("summary half selected without a paired entry");
`endif

endmodule

// ----- rtl/art_path_palette_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// art_path_palette_stream_parser_top
// Streaming parser for an embedded palette of texture path entries.
// ----------------------------------------------------------------------------
// Usage: write the file length to register 0 over the APB port, then
// stream the file one byte per request on data_byte with byte_valid.
// Each byte request is taken when byte_valid is high and byte_stall low.
// Records leave on the output channel (rec_valid, rec_stall) with one
// field per port: path bytes, entry done and abandon records, and an end
// summary after the last file byte. last_of_run marks the final record
// caused by an input byte.
// A record is queued when its byte is taken, then moves to the output register.
// Throughput: one byte per cycle unless byte_stall; one record per cycle
// unless rec_stall; the last byte can cause two records, one after the other.
// A four entry queue sits between the byte parser and the output
// register; byte_stall rises only when that queue is full, which happens
// only while rec_stall holds the output back.
// Reset clears the file length, the parser and the queue. Writing the
// file length restarts parsing; write it only while no records are due.
// ----------------------------------------------------------------------------
module art_path_palette_stream_parser_top #(
	parameter int MAX_PATH_LEN = appsp_pkg::MAX_PATH_LEN_DEF,
	parameter int MAX_ENTRIES  = appsp_pkg::MAX_ENTRIES_DEF,
	parameter int MIN_FILE_LEN = appsp_pkg::MIN_FILE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [appsp_pkg::PADDR_W-1:0] paddr,
	input  logic [appsp_pkg::PDATA_W-1:0] pwdata,
	output logic [appsp_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    data_byte,
	output logic                          rec_valid,
	input  logic                          rec_stall,
	output logic [1:0]                    record_kind,
	output logic                          which_path,
	output logic [7:0]                    path_byte,
	output logic [8:0]                    entry_index,
	output logic [31:0]                   tile_scale_bits,
	output logic [31:0]                   intensity_bits,
	output logic [31:0]                   table_offset,
	output logic [8:0]                    entry_count,
	output logic                          parse_ok,
	output logic                          last_of_run
);
	import appsp_pkg::*;

	logic        cfg_wr;
	logic [31:0] file_length;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	entry_t      q_in;
	entry_t      q_head;

	// register access
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && (paddr == REG_FILE_LENGTH);
	assign prdata     = (paddr == REG_FILE_LENGTH) ? file_length : '0;
	assign byte_stall = q_full;

	appsp_front #(
		.MAX_PATH_LEN (MAX_PATH_LEN),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.MIN_FILE_LEN (MIN_FILE_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.cfg_value   (pwdata),
		.file_length (file_length),
		.byte_valid  (byte_valid),
		.data_byte   (data_byte),
		.queue_full  (q_full),
		.push        (q_push),
		.push_entry  (q_in)
	);

	appsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	appsp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (q_head),
		.empty           (q_empty),
		.pop             (q_pop),
		.rec_stall       (rec_stall),
		.rec_valid       (rec_valid),
		.record_kind     (record_kind),
		.which_path      (which_path),
		.path_byte       (path_byte),
		.entry_index     (entry_index),
		.tile_scale_bits (tile_scale_bits),
		.intensity_bits  (intensity_bits),
		.table_offset    (table_offset),
		.entry_count     (entry_count),
		.parse_ok        (parse_ok),
		.last_of_run     (last_of_run)
	);

endmodule

// ----- sim/palette_record_checker.sv -----
// ----------------------------------------------------------------------------
// palette_record_checker
// Watches the byte, record and register channels of the palette path
// stream parser, keeps its own model of the parse, and compares every
// record that leaves the block, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module palette_record_checker #(
	parameter int MAX_PATH_LEN = appsp_pkg::MAX_PATH_LEN_DEF,
	parameter int MAX_ENTRIES  = appsp_pkg::MAX_ENTRIES_DEF,
	parameter int MIN_FILE_LEN = appsp_pkg::MIN_FILE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [appsp_pkg::PADDR_W-1:0] paddr,
	input  logic [appsp_pkg::PDATA_W-1:0] pwdata,
	input  logic                          byte_valid,
	input  logic                          byte_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          rec_valid,
	input  logic                          rec_stall,
	input  logic [1:0]                    record_kind,
	input  logic                          which_path,
	input  logic [7:0]                    path_byte,
	input  logic [8:0]                    entry_index,
	input  logic [31:0]                   tile_scale_bits,
	input  logic [31:0]                   intensity_bits,
	input  logic [31:0]                   table_offset,
	input  logic [8:0]                    entry_count,
	input  logic                          parse_ok,
	input  logic                          last_of_run,
	output int                            pending,
	output int                            fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import appsp_pkg::*;

	localparam logic [31:0] PATH_PREFIX = 32'h6172_745C;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		kind_t       kind;
		logic        which;
		logic [7:0]  pbyte;
		logic [8:0]  idx;
		logic [31:0] tile;
		logic [31:0] inten;
		logic [31:0] pal;
		logic [8:0]  cnt;
		logic        ok;
		logic        last;
	} rec_t;

	// parser model state
	logic [31:0] file_len;
	logic [31:0] pos;
	logic [31:0] pal_pos;
	logic [63:0] window;
	logic [63:0] meta_acc;
	phase_t      phase;
	int          seg_len;
	int          n_done;
	int          meta_n;

	rec_t due_records[$];

	task automatic report(input string msg);
		fails++;
		if (fails <= PRINT_CAP)
			$display("checker: %s", msg);
	endtask

	function automatic rec_t blank_rec(input kind_t k, input int idx);
		rec_t r;
		r = '0;
		r.kind = k;
		r.idx = idx[8:0];
		return r;
	endfunction

	function automatic logic prefix_char_ok(input int at, input logic [7:0] b);
		if (at > 3)
			return 1'b0;
		return b == PATH_PREFIX[8*(3-at) +: 8];
	endfunction

	task clear_parser();
		pos = '0;
		pal_pos = '0;
		window = '0;
		meta_acc = '0;
		phase = PH_SEARCH;
		seg_len = 0;
		n_done = 0;
		meta_n = 0;
	endtask

	// advance the parse by one file byte and queue the records it causes
	task parse_byte(input logic [7:0] b);
		rec_t        outs [2];
		int          n;
		logic        last_b;
		logic [31:0] p;
		logic [31:0] cnt;
		n = 0;
		if (pos >= file_len)
			return;
		p = pos;
		last_b = (p == file_len - 32'd1);
		pos = p + 32'd1;
		window = {window[55:0], b};

		if (file_len < MIN_FILE_LEN) begin
			if (last_b) begin
				outs[0] = blank_rec(KIND_SUMMARY, 0);
				n = 1;
			end
		end else begin
			case (phase)
				PH_SEARCH: begin
					if (p >= 32'd7 && !last_b && window[31:0] == PATH_PREFIX) begin
						cnt = window[63:32];
						if (cnt > 32'd1 && cnt < 32'd200) begin
							pal_pos = p - 32'd3;
							phase = PH_DIFF;
							seg_len = 4;
						end
					end
				end
				PH_DIFF, PH_NORM: begin
					if (last_b) begin
						outs[n] = blank_rec(KIND_ABANDON, n_done);
						n++;
						phase = PH_HALT;
					end else if (b == 8'd0) begin
						seg_len = 0;
						if (phase == PH_DIFF) begin
							phase = PH_NPRE;
						end else begin
							phase = PH_META;
							meta_n = 0;
							meta_acc = '0;
						end
					end else if (seg_len >= MAX_PATH_LEN) begin
						outs[n] = blank_rec(KIND_ABANDON, n_done);
						n++;
						phase = PH_HALT;
					end else begin
						outs[n] = blank_rec(KIND_PATH, n_done);
						outs[n].which = (phase == PH_NORM);
						outs[n].pbyte = b;
						n++;
						seg_len++;
					end
				end
				PH_NPRE: begin
					if (last_b || !prefix_char_ok(seg_len, b)) begin
						outs[n] = blank_rec(KIND_ABANDON, n_done);
						n++;
						phase = PH_HALT;
					end else begin
						seg_len++;
						if (seg_len == 4)
							phase = PH_NORM;
					end
				end
				PH_META: begin
					// metadata bytes one to eight hold the two float words
					if (meta_n >= 1 && meta_n <= 8)
						meta_acc = {meta_acc[55:0], b};
					if (meta_n >= 12) begin
						outs[n] = blank_rec(KIND_DONE, n_done);
						outs[n].tile = meta_acc[63:32];
						outs[n].inten = meta_acc[31:0];
						n++;
						n_done++;
						seg_len = 0;
						phase = (n_done > MAX_ENTRIES) ? PH_HALT : PH_NEXT;
					end else if (last_b) begin
						outs[n] = blank_rec(KIND_ABANDON, n_done);
						n++;
						phase = PH_HALT;
					end else begin
						meta_n++;
					end
				end
				PH_NEXT: begin
					// a failed next prefix ends the table quietly
					if (!prefix_char_ok(seg_len, b)) begin
						phase = PH_HALT;
					end else begin
						seg_len++;
						if (seg_len == 4)
							phase = last_b ? PH_HALT : PH_DIFF;
					end
				end
				default: begin
				end
			endcase

			if (last_b) begin
				outs[n] = blank_rec(KIND_SUMMARY, 0);
				outs[n].pal = pal_pos;
				outs[n].cnt = n_done[8:0];
				outs[n].ok = (n_done != 0);
				n++;
			end
		end

		for (int i = 0; i < n; i++) begin
			outs[i].last = (i == n - 1);
			due_records.insert(due_records.size(), outs[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want, input logic [8:0] idx);
		if (got !== want)
			report($sformatf("%s got %0h want %0h (entry %0d)", name, got, want, idx));
	endtask

	// compare one record leaving the block with the oldest one due
	task check_record();
		rec_t want;
		if (due_records.size() == 0) begin
			report($sformatf("record of kind %0d with nothing due", record_kind));
			return;
		end
		want = due_records.pop_front();
		check_field("record_kind", record_kind, want.kind, want.idx);
		check_field("which_path", which_path, want.which, want.idx);
		check_field("path_byte", path_byte, want.pbyte, want.idx);
		check_field("entry_index", entry_index, want.idx, want.idx);
		check_field("tile_scale_bits", tile_scale_bits, want.tile, want.idx);
		check_field("intensity_bits", intensity_bits, want.inten, want.idx);
		check_field("table_offset", table_offset, want.pal, want.idx);
		check_field("entry_count", entry_count, want.cnt, want.idx);
		check_field("parse_ok", parse_ok, want.ok, want.idx);
		check_field("last_of_run", last_of_run, want.last, want.idx);
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len = '0;
			clear_parser();
			due_records.delete();
			fails = 0;
		end else begin
			// a length write restarts the parse
			if (psel && penable && pwrite && pready && paddr == REG_FILE_LENGTH) begin
				file_len = pwdata;
				clear_parser();
			end
			if (byte_valid && !byte_stall)
				parse_byte(data_byte);
			if (rec_valid && !rec_stall)
				check_record();
		end
		pending = due_records.size();
	end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams generated files through the palette path stream parser: a few
// tiny files, shaped palettes that hit each special case of the parse,
// then random palettes, broken tables and noise under changing idle and
// stall patterns. A checker beside the block predicts every record.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import appsp_pkg::*;

	// total file bytes to stream over the whole run
	localparam int ITEM_TARGET    = 2000;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr      = '0;
	logic [PDATA_W-1:0] pwdata     = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	logic [7:0]         data_byte  = 8'd0;
	logic               rec_valid;
	logic               rec_stall  = 1'b0;
	logic [1:0]         record_kind;
	logic               which_path;
	logic [7:0]         path_byte;
	logic [8:0]         entry_index;
	logic [31:0]        tile_scale_bits;
	logic [31:0]        intensity_bits;
	logic [31:0]        table_offset;
	logic [8:0]         entry_count;
	logic               parse_ok;
	logic               last_of_run;
	int                 pending;
	int                 fails;

	// file under construction and landmarks inside it
	logic [7:0] file_q[$];
	int         entry_ends[$];
	int         norm_starts[$];

	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_at     = -1;
	int files_run   = 0;
	int items_done  = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	art_path_palette_stream_parser_top uut (.*);

	palette_record_checker records (.*);

	// receiver stall
	always @(posedge clk)
		rec_stall <= ($urandom_range(99) < stall_pct);

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((psel && penable) || (byte_valid && !byte_stall) || (rec_valid && !rec_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// mostly short paths, now and then one near the length limit
	function automatic int path_len();
		if ($urandom_range(99) == 0)
			return $urandom_range(MAX_PATH_LEN_DEF - 2, MAX_PATH_LEN_DEF - 6);
		return $urandom_range(8);
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(9))
			0: return 32'd2;
			1: return 32'd199;
			default: return $urandom_range(199, 2);
		endcase
	endfunction

	task set_idling(input int k);
		case (k % 5)
			1: begin
				idle_pct = 82;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 82;
			end
			3: begin
				idle_pct = 26;
				stall_pct = 26;
			end
			default: begin
				idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task append_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endtask

	task push_prefix();
		append_byte(8'h61);
		append_byte(8'h72);
		append_byte(8'h74);
		append_byte(8'h5C);
	endtask

	// junk head, big-endian count, entries, junk tail up to min_size
	task build_file(input int head, input logic [31:0] count, input int n_ent,
			input int dlen, input int nlen, input int min_size);
		int d;
		file_q.delete();
		entry_ends.delete();
		norm_starts.delete();
		repeat (head) append_byte(rand_byte());
		for (int k = 3; k >= 0; k--)
			append_byte(count[8*k +: 8]);
		for (int e = 0; e < n_ent; e++) begin
			push_prefix();
			d = (dlen < 0) ? path_len() : dlen;
			repeat (d) append_byte(8'($urandom_range(255, 1)));
			append_byte(8'd0);
			norm_starts.insert(norm_starts.size(), file_q.size());
			push_prefix();
			d = (nlen < 0) ? path_len() : nlen;
			repeat (d) append_byte(8'($urandom_range(255, 1)));
			append_byte(8'd0);
			repeat (13) append_byte(rand_byte());
			entry_ends.insert(entry_ends.size(), file_q.size());
		end
		while (file_q.size() < min_size)
			append_byte(rand_byte());
	endtask

	task apb_write(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FILE_LENGTH;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	// wait until every record due has left, then let the block go quiet
	task settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// set the length, then send the file up to that length and extras bytes past it
	task stream_file(input logic [31:0] len, input int extras);
		int n_file;
		settle();
		set_idling(files_run);
		files_run++;
		apb_write(len);
		n_file = (len < file_q.size()) ? int'(len) : file_q.size();
		for (int i = 0; i < n_file + extras; i++) begin
			if (i == hold_at) begin
				byte_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_byte(i < file_q.size() ? file_q[i] : rand_byte());
			if (i < len)
				items_done++;
		end
		byte_valid <= 1'b0;
	endtask

	initial begin
		int          base;
		int          r;
		int          c;
		int          extras;
		logic [31:0] len;
		int          cuts[$];

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty and tiny files with extreme byte values
		file_q = '{8'h00, 8'hFF};
		stream_file(32'd0, 2);
		file_q = '{8'hFF, 8'h00};
		stream_file(32'd1, 1);
		file_q = '{8'h00, 8'hA5, 8'h5A};
		stream_file(32'd3, 0);

		// smallest table at the minimum length, sender holding mid-file
		hold_at = 20;
		build_file(0, 32'd2, 1, 0, 0, MIN_FILE_LEN_DEF);
		stream_file(file_q.size(), 0);
		hold_at = -1;
		build_file(5, 32'd199, 3, -1, -1, MIN_FILE_LEN_DEF);
		stream_file(file_q.size(), 0);

		// counts just outside the accepted range
		build_file(3, 32'd1, 1, 2, 2, MIN_FILE_LEN_DEF);
		stream_file(file_q.size(), 0);
		build_file(3, 32'd200, 1, 2, 2, MIN_FILE_LEN_DEF);
		stream_file(file_q.size(), 0);

		// diffuse path at the length limit, normal path one past it
		build_file(0, 32'd10, 1, MAX_PATH_LEN_DEF - 4, MAX_PATH_LEN_DEF - 3, MIN_FILE_LEN_DEF);
		stream_file(file_q.size(), 0);

		// wrong normal prefix in the second entry
		build_file(2, 32'd7, 2, 3, 3, MIN_FILE_LEN_DEF);
		file_q[norm_starts[1] + 2] = 8'h78;
		stream_file(file_q.size(), 0);

		// first prefix ending on the last byte is not a match
		build_file(60, 32'd5, 1, 2, 2, MIN_FILE_LEN_DEF);
		stream_file(32'd68, 0);

		// file ending in each phase of an entry
		build_file(60, 32'd5, 2, 3, 3, MIN_FILE_LEN_DEF);
		base = entry_ends[0];
		cuts = '{norm_starts[0] - 2, norm_starts[0] + 1, base - 15, base - 3, base,
			base + 2, base + 4};
		foreach (cuts[i])
			stream_file(cuts[i], 0);

		// length never reached, then the same file with bytes past its end
		build_file(4, 32'd9, 2, -1, -1, MIN_FILE_LEN_DEF);
		stream_file(32'hFFFF_FFFF, 0);
		stream_file(file_q.size(), 6);

		// valid table cut below the minimum length
		build_file(0, 32'd5, 3, 1, 1, 0);
		stream_file(32'd63, 0);

		// random files
		while (items_done < ITEM_TARGET) begin
			r = $urandom_range(99);
			extras = 0;
			hold_at = ($urandom_range(19) == 0) ? $urandom_range(60, 1) : -1;
			if (r < 65) begin
				build_file($urandom_range(20), pick_count(), $urandom_range(4, 1), -1, -1,
					MIN_FILE_LEN_DEF);
				if ($urandom_range(3) == 0)
					file_q[$urandom_range(file_q.size() - 1)] = rand_byte();
				c = $urandom_range(99);
				if (c < 55) begin
					len = file_q.size();
				end else if (c < 85) begin
					len = $urandom_range(file_q.size(), 40);
				end else begin
					len = file_q.size();
					extras = $urandom_range(6, 1);
				end
			end else if (r < 80) begin
				if ($urandom_range(1) == 1) begin
					file_q.delete();
					repeat ($urandom_range(100, 64)) append_byte(rand_byte());
				end else begin
					build_file($urandom_range(8), $urandom(), 2, -1, -1, MIN_FILE_LEN_DEF);
				end
				len = file_q.size();
			end else if (r < 93) begin
				file_q.delete();
				repeat ($urandom_range(MIN_FILE_LEN_DEF - 1, 1)) append_byte(rand_byte());
				len = file_q.size();
				extras = $urandom_range(2);
			end else begin
				file_q.delete();
				repeat (10) append_byte(rand_byte());
				len = ($urandom_range(3) == 0) ? 32'd0 : 32'hFFFF_FFFF;
				// with no length every byte goes past the end
				if (len == 32'd0)
					extras = 10;
			end
			stream_file(len, extras);
		end
		hold_at = -1;

		settle();
		if (fails == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
